// ===== rtl/cleb_pkg.sv =====
// ----------------------------------------------------------------------------
// cleb_pkg
// Shared types and codes for the cursor line edit buffer.
// ----------------------------------------------------------------------------
package cleb_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_LEFT      = 3'd1,
        CMD_RIGHT     = 3'd2,
        CMD_BACKSPACE = 3'd3,
        CMD_FLUSH     = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] key_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       empty_line;
        logic       overflowed;
    } t_out_item;

    // per-cycle action of every cell in the row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,   // open a gap at the cursor and write the key there
        CELL_DELETE,   // close the gap before the cursor
        CELL_SHIFT     // whole row moves one toward cell 0
    } t_cell_op;

    typedef struct packed {
        t_cell_op   op;
        logic [7:0] key;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

endpackage

// ===== rtl/cleb_cell.sv =====
// ----------------------------------------------------------------------------
// cleb_cell
// One character position of the line; takes data from a neighbor or the key.
// ----------------------------------------------------------------------------
module cleb_cell
    import cleb_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic            i_clk,
    input  t_cell_ctl       i_ctl,
    input  logic [CW-1:0]   i_cursor,
    input  logic [7:0]      i_left,
    input  logic [7:0]      i_right,
    output logic [7:0]      o_char
);

    localparam logic [CW-1:0] IDX_V = CW'(IDX);

    logic [7:0] r_char;
    logic [7:0] n_char;
    logic       w_del_here;

    // cursor > 0 on delete, so IDX >= cursor-1 is IDX+1 >= cursor
    assign w_del_here = ({1'b0, IDX_V} + {{CW{1'b0}}, 1'b1}) >= {1'b0, i_cursor};

    always_comb begin
        n_char = r_char;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (IDX_V == i_cursor) begin
                    n_char = i_ctl.key;
                end else if (IDX_V > i_cursor) begin
                    n_char = i_left;
                end
            end
            CELL_DELETE: begin
                if (w_del_here) begin
                    n_char = i_right;
                end
            end
            CELL_SHIFT: n_char = i_right;
            default:    n_char = r_char;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;

endmodule

// ===== rtl/cursor_line_edit_buffer_top.sv =====
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_top
// Keystroke line editor: a row of character cells plus cursor and length.
// ----------------------------------------------------------------------------
// Latency/throughput: an edit command updates the line as it is accepted;
//   the next transfer is accepted on the following cycle.
// Flush: one result per cycle (none while output stalls) out of cell 0 while
//   the row shifts toward it (max(1, length) results); input stalls meanwhile.
// Reset (i_rst_n low, synchronous): empty line, cursor 0, overflow flag clear,
//   no result pending. Cell contents are not reset.
module cursor_line_edit_buffer_top
    import cleb_pkg::*;
#(
    parameter int LINE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_V = CW'(LINE_DEPTH);
    localparam logic [CW-1:0] ONE_V   = CW'(1);

    t_state      r_state, n_state;
    logic [CW-1:0] r_len, n_len;     // characters on the line
    logic [CW-1:0] r_cur, n_cur;     // cursor = characters left of it
    logic        r_drop, n_drop;     // insert dropped since last flush
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    t_cell_ctl   w_ctl;
    logic [7:0]  w_char [LINE_DEPTH];
    logic        w_accept;
    logic        w_slot_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    // output register can take a new result this cycle
    assign w_slot_free = !r_out_valid || i_out_ready;

    // ---- cell row: cell k holds the k-th character of the line ----
    for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
        logic [7:0] w_left;
        logic [7:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = 8'h00;
        end else begin : g_mid_l
            assign w_left = w_char[g-1];
        end
        if (g == LINE_DEPTH - 1) begin : g_last
            assign w_right = 8'h00;
        end else begin : g_mid_r
            assign w_right = w_char[g+1];
        end
        cleb_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_cursor (r_cur),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_char   (w_char[g])
        );
    end

    // ---- control ----
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_cur       = r_cur;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_ctl.op    = CELL_HOLD;
        w_ctl.key   = i_in_data.key_char;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.command)
                        CMD_INSERT: begin
                            if (r_len < DEPTH_V) begin
                                w_ctl.op = CELL_INSERT;
                                n_len    = r_len + ONE_V;
                                n_cur    = r_cur + ONE_V;
                            end else begin
                                n_drop = 1'b1;  // full line, key lost
                            end
                        end
                        CMD_LEFT: begin
                            if (r_cur != '0) begin
                                n_cur = r_cur - ONE_V;
                            end
                        end
                        CMD_RIGHT: begin
                            if (r_cur != r_len) begin
                                n_cur = r_cur + ONE_V;
                            end
                        end
                        CMD_BACKSPACE: begin
                            if (r_cur != '0) begin
                                w_ctl.op = CELL_DELETE;
                                n_cur    = r_cur - ONE_V;
                                n_len    = r_len - ONE_V;
                            end
                        end
                        CMD_FLUSH: n_state = ST_FLUSH;
                        default: ;      // unused codes do nothing
                    endcase
                end
            end
            ST_FLUSH: begin
                if (w_slot_free) begin
                    n_out_valid      = 1'b1;
                    n_out.overflowed = r_drop;
                    if (r_len == '0) begin
                        // empty line: single marker result
                        n_out.out_char   = 8'h00;
                        n_out.last       = 1'b1;
                        n_out.empty_line = 1'b1;
                        n_state          = ST_IDLE;
                        n_drop           = 1'b0;
                        n_cur            = '0;
                    end else begin
                        n_out.out_char   = w_char[0];
                        n_out.last       = (r_len == ONE_V);
                        n_out.empty_line = 1'b0;
                        w_ctl.op         = CELL_SHIFT;
                        n_len            = r_len - ONE_V;
                        if (r_len == ONE_V) begin
                            n_state = ST_IDLE;
                            n_drop  = 1'b0;
                            n_cur   = '0;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_cur       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_cur       <= n_cur;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/cleb_checker.sv =====
// ----------------------------------------------------------------------------
// cleb_props
// Port-level checks for the cursor line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
module cleb_props
    import cleb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // no result right after a reset cycle
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // empty-line marker is a single closing result with a zero character
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.empty_line) |->
            (o_out_data.last && (o_out_data.out_char == 8'h00)))
        else $error("malformed empty-line result");

    // input is held off while a flush still has characters to deliver
    a_flush_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> !o_in_ready)
        else $error("input accepted mid-flush");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // stalled command holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled command changed");

endmodule

bind cursor_line_edit_buffer_top cleb_props u_cleb_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/cleb_checker.sv =====
// ----------------------------------------------------------------------------
// cleb_checker
// Watches both channels of the line edit buffer, keeps its own copy of the
// line as two stacks, and compares each result transfer with the oldest
// predicted character.
// ----------------------------------------------------------------------------
module cleb_checker
    import cleb_pkg::*;
#(
    parameter int LINE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] left_chars  [LINE_DEPTH];
    logic [7:0] right_chars [LINE_DEPTH];
    int         left_len;
    int         right_len;
    logic       drop_seen;
    int         fails = 0;

    t_out_item  flushed_chars_q [$];

    function automatic t_out_item make_result(logic [7:0] ch, logic is_last,
                                              logic is_empty);
        t_out_item r;
        r.out_char   = ch;
        r.last       = is_last;
        r.empty_line = is_empty;
        r.overflowed = drop_seen;
        return r;
    endfunction

    // apply one command to the predicted line; flush queues the whole line
    task automatic edit_line(input t_in_item item);
        int total;
        int n;
        int i;
        total = left_len + right_len;
        n     = 0;
        case (item.command)
            CMD_INSERT: begin
                if (total < LINE_DEPTH) begin
                    left_chars[left_len] = item.key_char;
                    left_len++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            CMD_LEFT: begin
                if (left_len > 0) begin
                    left_len--;
                    right_chars[right_len] = left_chars[left_len];
                    right_len++;
                end
            end
            CMD_RIGHT: begin
                if (right_len > 0) begin
                    right_len--;
                    left_chars[left_len] = right_chars[right_len];
                    left_len++;
                end
            end
            CMD_BACKSPACE: begin
                if (left_len > 0)
                    left_len--;
            end
            CMD_FLUSH: begin
                if (total == 0) begin
                    flushed_chars_q.push_back(make_result(8'h00, 1'b1, 1'b1));
                end else begin
                    for (i = 0; i < left_len; i++) begin
                        flushed_chars_q.push_back(make_result(left_chars[i],
                                                              (n + 1) == total, 1'b0));
                        n++;
                    end
                    for (i = right_len; i > 0; i--) begin
                        flushed_chars_q.push_back(make_result(right_chars[i - 1],
                                                              (n + 1) == total, 1'b0));
                        n++;
                    end
                end
                left_len  = 0;
                right_len = 0;
                drop_seen = 1'b0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            left_len  = 0;
            right_len = 0;
            drop_seen = 1'b0;
            flushed_chars_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (flushed_chars_q.size() == 0) begin
                    $error("result transfer with nothing expected: out_char %h",
                           i_out_data.out_char);
                    fails++;
                end else begin
                    want = flushed_chars_q.pop_front();
                    if (want.out_char !== i_out_data.out_char) begin
                        $error("out_char: expected %h, actual %h", want.out_char,
                               i_out_data.out_char);
                        fails++;
                    end
                    if (want.last !== i_out_data.last) begin
                        $error("last: expected %b, actual %b", want.last, i_out_data.last);
                        fails++;
                    end
                    if (want.empty_line !== i_out_data.empty_line) begin
                        $error("empty_line: expected %b, actual %b", want.empty_line,
                               i_out_data.empty_line);
                        fails++;
                    end
                    if (want.overflowed !== i_out_data.overflowed) begin
                        $error("overflowed: expected %b, actual %b", want.overflowed,
                               i_out_data.overflowed);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                edit_line(i_in_data);
        end
        o_pending    <= flushed_chars_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/cursor_line_edit_buffer_top_tb.sv =====
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_top_tb
// Drives keystroke commands into the line edit buffer in random bursts while
// the result side stalls on its own pattern; a checker beside the block
// predicts every flushed character and counts mismatches.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_top_tb;

    import cleb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 64;

    // command codes the block has no name for; it must ignore them
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    // length of the one long receiver hold-off, in cycles
    localparam int HOLD_CYCLES = 300;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    int        fail_count;
    int        pending;

    // sender burst bookkeeping
    int        burst_left = 1;
    int        items_sent = 0;

    // handshake between the stimulus and the receiver for the long hold-off
    logic      hold_req  = 1'b0;
    logic      hold_done = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    cursor_line_edit_buffer_top #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    cleb_checker #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one command and hold it until the transfer happens. Bursts: after
    // a random number of back-to-back transfers the sender may drop valid for
    // a random gap; a gap of zero keeps valid up into the next burst.
    task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] key);
        t_in_item item;
        int       gap;
        item.command  = cmd;
        item.key_char = key;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // A short line of random edits, usually closed by a flush. Now and then
    // the line is longer, and a few commands are spare codes as noise.
    task automatic send_random_line();
        int         n_edits;
        int         pick;
        int         k;
        logic [2:0] spare;
        n_edits = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        for (k = 0; k < n_edits; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                send_cmd(CMD_INSERT, 8'($urandom_range(0, 255)));
            else if (pick < 12)
                send_cmd(CMD_LEFT, 8'($urandom_range(0, 255)));
            else if (pick < 15)
                send_cmd(CMD_RIGHT, 8'($urandom_range(0, 255)));
            else if (pick < 18)
                send_cmd(CMD_BACKSPACE, 8'($urandom_range(0, 255)));
            else begin
                spare = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                send_cmd(spare, 8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_cmd(CMD_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    // Receiver: segments of always-ready, coin-flip and mostly-stalled
    // patterns. Once the stimulus asks for it, ready stays low for a long
    // stretch so that a flush backs up and the input side stalls.
    initial begin
        int seg_len;
        int mode;
        forever begin
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                mode    = $urandom_range(0, 2);
                seg_len = $urandom_range(1, 40);
                repeat (seg_len) begin
                    case (mode)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= 1'($urandom_range(0, 1));
                        default: i_out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Main stimulus: reset, directed corner cases, then random lines.
    initial begin
        int k;
        int random_start;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // flush of an empty line gives the single empty marker
        send_cmd(CMD_FLUSH, 8'h00);
        // edits on an empty line are all ignored, spare codes too
        send_cmd(CMD_BACKSPACE, 8'hFF);
        send_cmd(CMD_LEFT, 8'h81);
        send_cmd(CMD_RIGHT, 8'h7E);
        send_cmd(CMD_SPARE_LO, 8'h55);
        send_cmd(CMD_SPARE_MID, 8'hAA);
        send_cmd(CMD_SPARE_HI, 8'hFF);
        // byte extremes, then cursor moves through the middle of the line
        send_cmd(CMD_INSERT, 8'h00);
        send_cmd(CMD_INSERT, 8'hFF);
        send_cmd(CMD_INSERT, 8'hA5);
        send_cmd(CMD_INSERT, 8'h5A);
        send_cmd(CMD_LEFT, 8'h00);
        send_cmd(CMD_LEFT, 8'h00);
        send_cmd(CMD_INSERT, 8'h3C);
        send_cmd(CMD_RIGHT, 8'h00);
        send_cmd(CMD_RIGHT, 8'h00);
        // move right at line end: ignored
        send_cmd(CMD_RIGHT, 8'hFF);
        send_cmd(CMD_BACKSPACE, 8'h00);
        send_cmd(CMD_LEFT, 8'h00);
        send_cmd(CMD_FLUSH, 8'hFF);

        random_start = items_sent;

        // Fill the line past its depth while the receiver holds off: dropped
        // inserts raise the overflow flag, moves work at full, and the final
        // flush backs up until the hold-off ends.
        hold_req = 1'b1;
        for (k = 0; k < LINE_DEPTH + 2; k++)
            send_cmd(CMD_INSERT, 8'($urandom_range(0, 255)));
        send_cmd(CMD_LEFT, 8'($urandom_range(0, 255)));
        send_cmd(CMD_LEFT, 8'($urandom_range(0, 255)));
        send_cmd(CMD_LEFT, 8'($urandom_range(0, 255)));
        send_cmd(CMD_INSERT, 8'($urandom_range(0, 255)));
        for (k = 0; k < 4; k++)
            send_cmd(CMD_RIGHT, 8'($urandom_range(0, 255)));
        send_cmd(CMD_BACKSPACE, 8'($urandom_range(0, 255)));
        send_cmd(CMD_INSERT, 8'($urandom_range(0, 255)));
        send_cmd(CMD_FLUSH, 8'($urandom_range(0, 255)));

        // a few random lines to close the run
        while (items_sent - random_start < 83)
            send_random_line();
        send_cmd(CMD_FLUSH, 8'($urandom_range(0, 255)));

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        // wait for every predicted character, then let the block settle
        while (pending != 0)
            @(posedge i_clk);
        repeat (LINE_DEPTH + 8) @(posedge i_clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule
